>>> sv/nmk_pkg.sv
package nmk_pkg;

    localparam int VAL_W         = 64;
    localparam int SET_W         = 32;
    localparam int SET_FRAC      = 16;
    localparam int FRAC_BITS_DEF = 32;
    localparam int REG_IDX_W     = 3;
    localparam int TYPE_W        = 2;
    localparam int MUL_LAT       = 4;
    localparam int PIPE_DEPTH    = 2 * MUL_LAT + 2;

    localparam logic [VAL_W-1:0] VAL_MAX     = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN     = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_MIN_MAG = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [SET_W-1:0] TIME_STEP_RST = SET_W'(65536);
    localparam logic [SET_W-1:0] ALPHA_RST     = SET_W'(32768);
    localparam logic [SET_W-1:0] BETA_RST      = SET_W'(32768);

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_CORRECT = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TIME_STEP     = 3'd0,
        REG_ALPHA_WEIGHT  = 3'd1,
        REG_BETA_WEIGHT   = 3'd2,
        REG_K_WEIGHT      = 3'd3,
        REG_H_WEIGHT      = 3'd4,
        REG_SOLUTION_TYPE = 3'd5
    } reg_idx_t;

    typedef enum logic [TYPE_W-1:0] {
        SOL_ACC   = 2'd0,
        SOL_VEL   = 2'd1,
        SOL_DISP  = 2'd2,
        SOL_UNDEF = 2'd3
    } sol_t;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        val_t val;
        logic sat;
    } sval_t;

    typedef struct packed {
        logic cmd;
        logic blocked;
        val_t disp_in;
        val_t vel_in;
        val_t acc_in;
        val_t increment;
    } dof_t;

    typedef struct packed {
        val_t disp_out;
        val_t vel_out;
        val_t acc_out;
        logic saturated;
    } upd_t;

    typedef struct packed {
        logic [SET_W-1:0] dt;
        val_t             c1dt;
        val_t             c2dt;
        val_t             c3;
        val_t             c4;
        val_t             c5;
        val_t             e;
        val_t             d;
        val_t             c;
        logic             pred_sat;
        logic             corr_sat;
        logic             pass_corr;
    } coef_t;

    // magnitude q with sign neg, saturated to the signed range
    function automatic sval_t sat_build(input logic neg, input logic [2*VAL_W-1:0] q);
        logic             over;
        logic [VAL_W-1:0] m;
        sval_t            r;
        over = |q[2*VAL_W-1:VAL_W];
        m    = q[VAL_W-1:0];
        if (neg)
        begin
            if (over || (m > VAL_MIN_MAG))
            begin
                r.val = VAL_MIN;
                r.sat = 1'b1;
            end
            else
            begin
                r.val = VAL_W'(0) - m;
                r.sat = 1'b0;
            end
        end
        else
        begin
            if (over || m[VAL_W-1])
            begin
                r.val = VAL_MAX;
                r.sat = 1'b1;
            end
            else
            begin
                r.val = m;
                r.sat = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic sval_t sat_fix(input logic signed [VAL_W:0] s);
        sval_t r;
        if (s[VAL_W] != s[VAL_W-1])
        begin
            r.val = s[VAL_W] ? VAL_MIN : VAL_MAX;
            r.sat = 1'b1;
        end
        else
        begin
            r.val = s[VAL_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic sval_t sat_add(input val_t a, input val_t b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        return sat_fix(s);
    endfunction

    function automatic sval_t sat_sub(input val_t a, input val_t b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        return sat_fix(s);
    endfunction

endpackage

>>> sv/nmk_dof_if.sv
interface nmk_dof_if import nmk_pkg::*; ();
    logic cmd;
    logic blocked;
    val_t disp_in;
    val_t vel_in;
    val_t acc_in;
    val_t increment;
    logic valid;
    logic ready;

    modport source (output valid, cmd, blocked, disp_in, vel_in, acc_in, increment,
                    input ready);
    modport sink (input valid, cmd, blocked, disp_in, vel_in, acc_in, increment,
                  output ready);
endinterface

>>> sv/nmk_upd_if.sv
interface nmk_upd_if import nmk_pkg::*; ();
    val_t disp_out;
    val_t vel_out;
    val_t acc_out;
    logic saturated;
    logic valid;
    logic ready;

    modport source (output valid, disp_out, vel_out, acc_out, saturated, input ready);
    modport sink (input valid, disp_out, vel_out, acc_out, saturated, output ready);
endinterface

>>> sv/nmk_mulq.sv
// a*b >> SHIFT on magnitudes, truncated toward zero, saturated; four stages
module nmk_mulq import nmk_pkg::*;
#(
    parameter int SHIFT = SET_FRAC
)
(
    input  logic  clk,
    input  logic  en,
    input  val_t  a,
    input  val_t  b,
    output sval_t res
);

    localparam int HW = VAL_W / 2;

    logic [VAL_W-1:0]   ma_reg, mb_reg;
    logic               neg_a_reg, neg_b_reg, neg_c_reg;
    logic [VAL_W-1:0]   pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [2*VAL_W-1:0] prod_reg;
    sval_t              res_reg;
    logic [2*VAL_W-1:0] q;

    assign q = prod_reg >> SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg    <= a[VAL_W-1] ? VAL_W'(0) - a : a;
            mb_reg    <= b[VAL_W-1] ? VAL_W'(0) - b : b;
            neg_a_reg <= a[VAL_W-1] ^ b[VAL_W-1];

            pp00_reg  <= ma_reg[HW-1:0]     * mb_reg[HW-1:0];
            pp01_reg  <= ma_reg[HW-1:0]     * mb_reg[VAL_W-1:HW];
            pp10_reg  <= ma_reg[VAL_W-1:HW] * mb_reg[HW-1:0];
            pp11_reg  <= ma_reg[VAL_W-1:HW] * mb_reg[VAL_W-1:HW];
            neg_b_reg <= neg_a_reg;

            prod_reg  <= {{VAL_W{1'b0}}, pp00_reg}
                       + ({{VAL_W{1'b0}}, pp01_reg} << HW)
                       + ({{VAL_W{1'b0}}, pp10_reg} << HW)
                       + {pp11_reg, {VAL_W{1'b0}}};
            neg_c_reg <= neg_b_reg;

            res_reg   <= sat_build(neg_c_reg, q);
        end
    end

    assign res = res_reg;

endmodule

>>> sv/nmk_coef.sv
// settings registers and serial coefficient sequencer
module nmk_coef import nmk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [SET_W-1:0]     wr_data,
    output coef_t                coef,
    output logic                 ready
);

    localparam int PROD_W = VAL_W + SET_W;
    localparam int CNT_W  = $clog2(SET_W);
    localparam int IDX_W  = $clog2(2 * VAL_W);
    localparam logic [VAL_W-1:0] ONE  = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] HALF = VAL_W'(1) << (FRAC_BITS - 1);
    localparam logic [IDX_W-1:0] RCP_BIT = IDX_W'(2 * FRAC_BITS);
    localparam logic [IDX_W-1:0] Q_TOP   = IDX_W'(VAL_W - 1);

    typedef enum logic [4:0] {
        ST_KQ, ST_HQ, ST_C1, ST_C2A, ST_C2B, ST_C4, ST_C1DT, ST_C2DT,
        ST_BQ, ST_BDT, ST_AQ, ST_ADT, ST_X1, ST_X2, ST_RB, ST_RX, ST_RA, ST_DONE
    } step_t;

    typedef enum logic [1:0] {PH_LOAD, PH_RUN, PH_WRITE} phase_t;

    step_t              step_reg;
    phase_t             phase_reg;
    logic [SET_W-1:0]   dt_reg, alpha_reg, beta_reg, k_reg, h_reg;
    logic [TYPE_W-1:0]  type_reg;
    val_t               kq_reg, hq_reg, tmp_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    val_t               c1dt_reg, c2dt_reg, bdt_reg, adt_reg, x_reg, rb_reg, rx_reg, ra_reg;
    logic               psat_reg, bsat_reg, xsat_reg, rbsat_reg, rxsat_reg, rasat_reg;
    logic [PROD_W-1:0]  acc_reg, msh_reg;
    logic [SET_W-1:0]   sh_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg;
    logic [VAL_W-1:0]   ux_reg, rem_reg;
    logic [VAL_W-2:0]   q_reg;
    logic [IDX_W-1:0]   i_reg;
    logic               over_reg, rbad_reg;

    val_t               op_a, rc_x;
    logic [SET_W-1:0]   op_s;
    logic               is_rcp;
    sval_t              mres, rres, sub_one, sub_half, sub_c3, sub_c5;
    logic [VAL_W-1:0]   rem_sh;

    always_comb
    begin
        op_a   = ONE;
        op_s   = dt_reg;
        rc_x   = bdt_reg;
        is_rcp = 1'b0;
        unique case (step_reg)
            ST_KQ:   op_s = k_reg;
            ST_HQ:   op_s = h_reg;
            ST_C1:   begin op_a = kq_reg;   op_s = alpha_reg; end
            ST_C2A:  begin op_a = hq_reg;   op_s = alpha_reg; end
            ST_C2B:  begin op_a = tmp_reg;  op_s = beta_reg;  end
            ST_C4:   begin op_a = hq_reg;   op_s = beta_reg;  end
            ST_C1DT: op_a = c1_reg;
            ST_C2DT: op_a = c2_reg;
            ST_BQ:   op_s = beta_reg;
            ST_BDT:  op_a = tmp_reg;
            ST_AQ:   op_s = alpha_reg;
            ST_ADT:  op_a = tmp_reg;
            ST_X1:   begin op_a = bdt_reg;  op_s = alpha_reg; end
            ST_X2:   op_a = tmp_reg;
            ST_RB:   is_rcp = 1'b1;
            ST_RX:   begin rc_x = x_reg;   is_rcp = 1'b1; end
            ST_RA:   begin rc_x = adt_reg; is_rcp = 1'b1; end
            ST_DONE: is_rcp = 1'b0;
        endcase
    end

    assign mres     = sat_build(neg_reg, (2*VAL_W)'(acc_reg >> SET_FRAC));
    assign rres.val = (rbad_reg || over_reg) ? VAL_MAX : VAL_W'(q_reg);
    assign rres.sat = rbad_reg || over_reg;
    assign sub_one  = sat_sub(ONE, mres.val);
    assign sub_half = sat_sub(HALF, mres.val);
    assign sub_c3   = sat_sub(ONE, kq_reg);
    assign sub_c5   = sat_sub(ONE, hq_reg);
    assign rem_sh   = {rem_reg[VAL_W-2:0], i_reg == RCP_BIT};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_KQ;
            phase_reg <= PH_LOAD;
            dt_reg    <= TIME_STEP_RST;
            alpha_reg <= ALPHA_RST;
            beta_reg  <= BETA_RST;
            k_reg     <= '0;
            h_reg     <= '0;
            type_reg  <= SOL_ACC;
            kq_reg    <= '0;  hq_reg   <= '0;  tmp_reg  <= '0;
            c1_reg    <= '0;  c2_reg   <= '0;  c3_reg   <= '0;
            c4_reg    <= '0;  c5_reg   <= '0;  c1dt_reg <= '0;
            c2dt_reg  <= '0;  bdt_reg  <= '0;  adt_reg  <= '0;
            x_reg     <= '0;  rb_reg   <= '0;  rx_reg   <= '0;
            ra_reg    <= '0;
            psat_reg  <= 1'b0; bsat_reg  <= 1'b0; xsat_reg  <= 1'b0;
            rbsat_reg <= 1'b0; rxsat_reg <= 1'b0; rasat_reg <= 1'b0;
            acc_reg   <= '0;  msh_reg  <= '0;  sh_reg   <= '0;
            cnt_reg   <= '0;  neg_reg  <= 1'b0;
            ux_reg    <= '0;  rem_reg  <= '0;  q_reg    <= '0;
            i_reg     <= '0;  over_reg <= 1'b0; rbad_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TIME_STEP:     dt_reg    <= wr_data;
                REG_ALPHA_WEIGHT:  alpha_reg <= wr_data;
                REG_BETA_WEIGHT:   beta_reg  <= wr_data;
                REG_K_WEIGHT:      k_reg     <= wr_data;
                REG_H_WEIGHT:      h_reg     <= wr_data;
                REG_SOLUTION_TYPE: type_reg  <= wr_data[TYPE_W-1:0];
                default:           ;
            endcase
            step_reg  <= ST_KQ;
            phase_reg <= PH_LOAD;
            psat_reg  <= 1'b0; bsat_reg  <= 1'b0; xsat_reg  <= 1'b0;
            rbsat_reg <= 1'b0; rxsat_reg <= 1'b0; rasat_reg <= 1'b0;
        end
        else if (step_reg != ST_DONE)
        begin
            unique case (phase_reg)
                PH_LOAD:
                begin
                    if (is_rcp)
                    begin
                        ux_reg   <= rc_x;
                        rem_reg  <= '0;
                        q_reg    <= '0;
                        i_reg    <= IDX_W'(2 * VAL_W - 1);
                        over_reg <= 1'b0;
                        rbad_reg <= rc_x[VAL_W-1] || (rc_x == '0);
                        phase_reg <= (rc_x[VAL_W-1] || (rc_x == '0)) ? PH_WRITE : PH_RUN;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        msh_reg   <= PROD_W'(op_a[VAL_W-1] ? VAL_W'(0) - op_a : op_a);
                        sh_reg    <= op_s;
                        neg_reg   <= op_a[VAL_W-1];
                        cnt_reg   <= '0;
                        phase_reg <= PH_RUN;
                    end
                end
                PH_RUN:
                begin
                    if (is_rcp)
                    begin
                        if (rem_sh >= ux_reg)
                        begin
                            rem_reg <= rem_sh - ux_reg;
                            if (i_reg >= Q_TOP)
                                over_reg <= 1'b1;
                            else
                                q_reg[i_reg[IDX_W-2:0]] <= 1'b1;
                        end
                        else
                            rem_reg <= rem_sh;
                        i_reg <= i_reg - 1'b1;
                        if (i_reg == '0)
                            phase_reg <= PH_WRITE;
                    end
                    else
                    begin
                        if (sh_reg[0])
                            acc_reg <= acc_reg + msh_reg;
                        msh_reg <= msh_reg << 1;
                        sh_reg  <= sh_reg >> 1;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CNT_W'(SET_W - 1))
                            phase_reg <= PH_WRITE;
                    end
                end
                PH_WRITE:
                begin
                    phase_reg <= PH_LOAD;
                    unique case (step_reg)
                        ST_KQ:
                        begin
                            kq_reg <= mres.val; psat_reg <= psat_reg | mres.sat;
                            step_reg <= ST_HQ;
                        end
                        ST_HQ:
                        begin
                            hq_reg <= mres.val; psat_reg <= psat_reg | mres.sat;
                            step_reg <= ST_C1;
                        end
                        ST_C1:
                        begin
                            c1_reg <= sub_one.val;
                            psat_reg <= psat_reg | mres.sat | sub_one.sat;
                            step_reg <= ST_C2A;
                        end
                        ST_C2A:
                        begin
                            tmp_reg <= mres.val; psat_reg <= psat_reg | mres.sat;
                            step_reg <= ST_C2B;
                        end
                        ST_C2B:
                        begin
                            c2_reg <= sub_half.val;
                            psat_reg <= psat_reg | mres.sat | sub_half.sat;
                            step_reg <= ST_C4;
                        end
                        ST_C4:
                        begin
                            c4_reg <= sub_one.val;
                            c3_reg <= sub_c3.val;
                            c5_reg <= sub_c5.val;
                            psat_reg <= psat_reg | mres.sat | sub_one.sat
                                      | sub_c3.sat | sub_c5.sat;
                            step_reg <= ST_C1DT;
                        end
                        ST_C1DT:
                        begin
                            c1dt_reg <= mres.val; psat_reg <= psat_reg | mres.sat;
                            step_reg <= ST_C2DT;
                        end
                        ST_C2DT:
                        begin
                            c2dt_reg <= mres.val; psat_reg <= psat_reg | mres.sat;
                            step_reg <= ST_BQ;
                        end
                        ST_BQ:
                        begin
                            tmp_reg <= mres.val; bsat_reg <= bsat_reg | mres.sat;
                            step_reg <= ST_BDT;
                        end
                        ST_BDT:
                        begin
                            bdt_reg <= mres.val; bsat_reg <= bsat_reg | mres.sat;
                            step_reg <= ST_AQ;
                        end
                        ST_AQ:
                        begin
                            tmp_reg <= mres.val; bsat_reg <= bsat_reg | mres.sat;
                            step_reg <= ST_ADT;
                        end
                        ST_ADT:
                        begin
                            adt_reg <= mres.val; bsat_reg <= bsat_reg | mres.sat;
                            step_reg <= ST_X1;
                        end
                        ST_X1:
                        begin
                            tmp_reg <= mres.val; xsat_reg <= xsat_reg | mres.sat;
                            step_reg <= ST_X2;
                        end
                        ST_X2:
                        begin
                            x_reg <= mres.val; xsat_reg <= xsat_reg | mres.sat;
                            step_reg <= ST_RB;
                        end
                        ST_RB:
                        begin
                            rb_reg <= rres.val; rbsat_reg <= rres.sat;
                            step_reg <= ST_RX;
                        end
                        ST_RX:
                        begin
                            rx_reg <= rres.val; rxsat_reg <= rres.sat;
                            step_reg <= ST_RA;
                        end
                        ST_RA:
                        begin
                            ra_reg <= rres.val; rasat_reg <= rres.sat;
                            step_reg <= ST_DONE;
                        end
                        ST_DONE: step_reg <= ST_DONE;
                    endcase
                end
                default: phase_reg <= PH_LOAD;
            endcase
        end
    end

    always_comb
    begin
        coef.dt        = dt_reg;
        coef.c1dt      = c1dt_reg;
        coef.c2dt      = c2dt_reg;
        coef.c3        = c3_reg;
        coef.c4        = c4_reg;
        coef.c5        = c5_reg;
        coef.pred_sat  = psat_reg;
        coef.pass_corr = 1'b0;
        unique case (type_reg)
            SOL_VEL:
            begin
                coef.c = rb_reg; coef.d = ONE; coef.e = adt_reg;
                coef.corr_sat = bsat_reg | rbsat_reg;
            end
            SOL_DISP:
            begin
                coef.c = rx_reg; coef.d = ra_reg; coef.e = ONE;
                coef.corr_sat = bsat_reg | xsat_reg | rxsat_reg | rasat_reg;
            end
            SOL_UNDEF:
            begin
                coef.c = ONE; coef.d = bdt_reg; coef.e = x_reg;
                coef.corr_sat  = 1'b0;
                coef.pass_corr = 1'b1;
            end
            default:
            begin
                coef.c = ONE; coef.d = bdt_reg; coef.e = x_reg;
                coef.corr_sat = bsat_reg | xsat_reg;
            end
        endcase
    end

    assign ready = (step_reg == ST_DONE);

endmodule

>>> sv/nmk_pipe.sv
// per-item datapath: da product, five lane products, two saturating add stages
module nmk_pipe import nmk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  dof_t  item,
    input  coef_t coef,
    output logic  out_valid,
    output upd_t  result
);

    localparam int DLY   = PIPE_DEPTH - 1;
    localparam int LANES = 5;
    localparam int AT_M2 = MUL_LAT - 1;
    localparam int AT_A1 = 2 * MUL_LAT - 1;
    localparam int AT_FN = 2 * MUL_LAT;

    logic [PIPE_DEPTH-1:0] vld_reg;
    dof_t                  item_reg [DLY];
    logic [MUL_LAT-1:0]    dsat_reg;
    val_t                  au_reg, av_reg, aa_reg;
    logic                  af_reg;
    upd_t                  res_reg;

    val_t  dt_ext;
    sval_t da;
    val_t  m_a [LANES];
    val_t  m_b [LANES];
    sval_t m_r [LANES];
    logic  pred2, pred1, pred0, pass;
    sval_t su, sv, sa, fu;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= item;
            for (int i = 1; i < DLY; i++)
                item_reg[i] <= item_reg[i-1];
            dsat_reg <= {dsat_reg[MUL_LAT-2:0], da.sat};
        end
    end

    assign dt_ext = VAL_W'(coef.dt);

    nmk_mulq #(.SHIFT(SET_FRAC)) u_mul_da (
        .clk (clk),
        .en  (en),
        .a   (item.acc_in),
        .b   (dt_ext),
        .res (da)
    );

    assign pred2 = (item_reg[AT_M2].cmd == CMD_PREDICT);

    always_comb
    begin
        m_a[0] = pred2 ? coef.c1dt : coef.e;
        m_b[0] = pred2 ? item_reg[AT_M2].vel_in : item_reg[AT_M2].increment;
        m_a[1] = coef.c2dt;
        m_b[1] = da.val;
        m_a[2] = pred2 ? coef.c3 : coef.d;
        m_b[2] = pred2 ? item_reg[AT_M2].vel_in : item_reg[AT_M2].increment;
        m_a[3] = coef.c4;
        m_b[3] = da.val;
        m_a[4] = pred2 ? coef.c5 : coef.c;
        m_b[4] = pred2 ? item_reg[AT_M2].acc_in : item_reg[AT_M2].increment;
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        nmk_mulq #(.SHIFT(FRAC_BITS)) u_mul (
            .clk (clk),
            .en  (en),
            .a   (m_a[g]),
            .b   (m_b[g]),
            .res (m_r[g])
        );
    end

    assign pred1 = (item_reg[AT_A1].cmd == CMD_PREDICT);

    always_comb
    begin
        if (pred1)
        begin
            su = sat_add(m_r[0].val, m_r[1].val);
            sv = sat_add(m_r[2].val, m_r[3].val);
            sa = m_r[4];
        end
        else
        begin
            su = sat_add(item_reg[AT_A1].disp_in, m_r[0].val);
            sv = sat_add(item_reg[AT_A1].vel_in, m_r[2].val);
            sa = sat_add(item_reg[AT_A1].acc_in, m_r[4].val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            au_reg <= su.val;
            av_reg <= sv.val;
            aa_reg <= sa.val;
            if (pred1)
                af_reg <= dsat_reg[MUL_LAT-1] | m_r[0].sat | m_r[1].sat | m_r[2].sat
                        | m_r[3].sat | m_r[4].sat | su.sat | sv.sat;
            else
                af_reg <= m_r[0].sat | m_r[2].sat | m_r[4].sat | su.sat | sv.sat | sa.sat;
        end
    end

    assign pred0 = (item_reg[AT_FN].cmd == CMD_PREDICT);
    assign pass  = item_reg[AT_FN].blocked || (!pred0 && coef.pass_corr);
    assign fu    = sat_add(item_reg[AT_FN].disp_in, au_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pass)
            begin
                res_reg.disp_out  <= item_reg[AT_FN].disp_in;
                res_reg.vel_out   <= item_reg[AT_FN].vel_in;
                res_reg.acc_out   <= item_reg[AT_FN].acc_in;
                res_reg.saturated <= 1'b0;
            end
            else if (pred0)
            begin
                res_reg.disp_out  <= fu.val;
                res_reg.vel_out   <= av_reg;
                res_reg.acc_out   <= aa_reg;
                res_reg.saturated <= af_reg | fu.sat | coef.pred_sat;
            end
            else
            begin
                res_reg.disp_out  <= au_reg;
                res_reg.vel_out   <= av_reg;
                res_reg.acc_out   <= aa_reg;
                res_reg.saturated <= af_reg | coef.corr_sat;
            end
        end
    end

    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign result    = res_reg;

endmodule

>>> sv/newmark_dof_update.sv
// Newmark-beta update of one degree of freedom per item.
// dof: input items (cmd predict/correct, blocked, displacement, velocity,
//   acceleration, increment), valid/ready; taken when both are high.
// upd: one result item per input item, in order, valid/ready.
// wr_en/wr_index/wr_data: settings write, one register per cycle.
// One item per cycle sustained while upd is not stalled and the
//   coefficients are ready, set by the fully pipelined 64x64 products (four partial
//   products each, four stages) and two saturating add stages.
// After reset and after every settings write the coefficient sequencer
//   recomputes its values with one serial multiplier (14 products) and a
//   restoring divider (3 reciprocals), during which dof.ready is low.
// A stalled upd holds its item; the whole pipeline freezes and dof.ready
//   drops, so nothing is lost or repeated.
module newmark_dof_update import nmk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    nmk_dof_if.sink              dof,
    nmk_upd_if.source            upd,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [SET_W-1:0]     wr_data
);

    coef_t coef;
    logic  coef_rdy;
    logic  en;
    logic  accept;
    logic  pipe_valid;
    dof_t  item;
    upd_t  result;

    nmk_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .coef     (coef),
        .ready    (coef_rdy)
    );

    assign en        = !pipe_valid || upd.ready;
    assign dof.ready = en && coef_rdy;
    assign accept    = dof.valid && dof.ready;

    assign item.cmd       = dof.cmd;
    assign item.blocked   = dof.blocked;
    assign item.disp_in   = dof.disp_in;
    assign item.vel_in    = dof.vel_in;
    assign item.acc_in    = dof.acc_in;
    assign item.increment = dof.increment;

    nmk_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (accept),
        .item      (item),
        .coef      (coef),
        .out_valid (pipe_valid),
        .result    (result)
    );

    assign upd.valid     = pipe_valid;
    assign upd.disp_out  = result.disp_out;
    assign upd.vel_out   = result.vel_out;
    assign upd.acc_out   = result.acc_out;
    assign upd.saturated = result.saturated;

endmodule

>>> sv/nmk_checker.sv
module nmk_checker import nmk_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic dof_valid,
    input logic dof_ready,
    input logic upd_valid,
    input logic upd_ready,
    input val_t upd_disp,
    input logic upd_sat,
    input logic wr_en
);

    localparam int CW = $clog2(PIPE_DEPTH + 1) + 1;

    logic [CW-1:0] in_flight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_flight_reg <= '0;
        else
            in_flight_reg <= in_flight_reg + CW'(dof_valid && dof_ready)
                           - CW'(upd_valid && upd_ready);
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid && !upd_ready |=> upd_valid && $stable(upd_disp) && $stable(upd_sat))
        else $error("result item changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid |-> in_flight_reg != '0)
        else $error("result item without an accepted input item");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= CW'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !dof_ready)
        else $error("input taken while coefficients are recomputed");

    a_rst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !dof_ready)
        else $error("input taken straight after reset");

endmodule

bind newmark_dof_update nmk_checker u_nmk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .dof_valid (dof.valid),
    .dof_ready (dof.ready),
    .upd_valid (upd.valid),
    .upd_ready (upd.ready),
    .upd_disp  (upd.disp_out),
    .upd_sat   (upd.saturated),
    .wr_en     (wr_en)
);
